// ===== design/cap_pkg.sv =====
// Shared types and constants for the Clifford attractor point generator.
package cap_pkg;

    localparam int COEF_W = 15;
    localparam int OUT_W  = 14;
    localparam int NUM_ATAN = 28;

    // Register addresses (byte address / 4)
    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_COEF_D = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] K_Q30  = 32'd652032874;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd843314857;
                5'd1:  r = 32'd497837829;
                5'd2:  r = 32'd263043837;
                5'd3:  r = 32'd133525159;
                5'd4:  r = 32'd67021687;
                5'd5:  r = 32'd33543516;
                5'd6:  r = 32'd16775851;
                5'd7:  r = 32'd8388437;
                5'd8:  r = 32'd4194283;
                5'd9:  r = 32'd2097149;
                default: r = (i < 5'd28) ? (32'd1 << (5'd30 - i)) : 32'd0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic restart;
    } cap_req_t;

endpackage

// ===== design/cap_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface cap_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface cap_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] point_x;
    logic signed [13:0] point_y;
    logic signed [13:0] point_z;
    logic [19:0]        point_index;
    logic               last;
    modport source (output valid, output point_x, output point_y, output point_z,
                    output point_index, output last, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  input point_index, input last, output ready);
endinterface

// ===== design/cap_front.sv =====
// Front end: accepts requests and queues them in a two-entry FIFO.
module cap_front
    import cap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     in_restart,
    output logic     q_valid,
    input  logic     q_pop,
    output cap_req_t q_data
);
    cap_req_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].restart <= in_restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !(q_pop && q_valid)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
`endif
endmodule

// ===== design/cap_cordic.sv =====
// Iterative sine/cosine CORDIC with range reduction, one step per cycle.
module cap_cordic
    import cap_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18,
    parameter int AW           = FRAC_BITS + 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    angle,
    output logic                    done,
    output logic signed [AW-1:0]    sin_out,
    output logic signed [AW-1:0]    cos_out
);
    localparam int SW = (CORDIC_STEPS < NUM_ATAN) ? CORDIC_STEPS : NUM_ATAN;
    localparam int IW = $clog2(SW + 1);
    localparam logic [31:0] RND = 32'd1 << (29 - FRAC_BITS);
    localparam logic [31:0] PI_R = (PI_Q30 + RND) >> (30 - FRAC_BITS);
    localparam logic [31:0] HPI_R = ((PI_Q30 >> 1) + RND) >> (30 - FRAC_BITS);
    localparam logic [31:0] K_R = (K_Q30 + RND) >> (30 - FRAC_BITS);
    localparam logic signed [AW-1:0] PI_S   = AW'(PI_R);
    localparam logic signed [AW-1:0] HPI_S  = AW'(HPI_R);
    localparam logic signed [AW-1:0] TPI_S  = AW'({PI_R, 1'b0});

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]              st_reg, st_next;
    logic signed [AW-1:0]    r_reg, r_next;
    logic signed [AW-1:0]    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                    neg_reg, neg_next;
    logic [IW-1:0]           i_reg, i_next;
    logic signed [AW-1:0]    dx, dy, t, zr;
    logic [31:0]             atn;

    assign atn = atan_q30(5'(i_reg));
    assign t   = AW'((atn + RND) >> (30 - FRAC_BITS));
    assign dx  = y_reg >>> i_reg;
    assign dy  = x_reg >>> i_reg;
    assign zr  = r_reg - PI_S;

    // range reduction: subtract/add 2*pi one step per cycle (angle is bounded)
    always_comb
    begin
        st_next  = st_reg;
        r_next   = r_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        neg_next = neg_reg;
        i_next   = i_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r_next  = angle + PI_S;
                    st_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (r_reg < 0)
                begin
                    r_next = r_reg + TPI_S;
                end
                else if (r_reg >= TPI_S)
                begin
                    r_next = r_reg - TPI_S;
                end
                else
                begin
                    st_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                neg_next = 1'b0;
                z_next   = zr;
                if (zr > HPI_S)
                begin
                    z_next   = PI_S - zr;
                    neg_next = 1'b1;
                end
                else if (zr < -HPI_S)
                begin
                    z_next   = -PI_S - zr;
                    neg_next = 1'b1;
                end
                x_next  = AW'(K_R);
                y_next  = '0;
                i_next  = '0;
                st_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - t;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + t;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == IW'(SW - 1))
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        i_reg   <= i_next;
    end

    assign done    = (st_reg == ST_DONE);
    assign sin_out = y_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == ST_IDLE) else $error("start while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_ITER |-> i_reg < IW'(SW)) else $error("step overrun");
`endif
endmodule

// ===== design/cap_back.sv =====
// Back end: runs the map for one queued request and holds the result.
module cap_back
    import cap_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_WIDTH  = 20,
    parameter int CORDIC_STEPS = 18
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  cap_req_t                 q_data,
    input  logic [COEF_W-1:0]        coef_a,
    input  logic [COEF_W-1:0]        coef_b,
    input  logic [COEF_W-1:0]        coef_c,
    input  logic [COEF_W-1:0]        coef_d,
    input  logic [19:0]              point_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  point_x,
    output logic signed [OUT_W-1:0]  point_y,
    output logic signed [OUT_W-1:0]  point_z,
    output logic [19:0]              point_index,
    output logic                     last
);
    localparam int PW = FRAC_BITS + 5;
    localparam int AW = FRAC_BITS + 16;
    localparam int CW = (COUNT_WIDTH > 20) ? COUNT_WIDTH + 1 : 21;
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] PHI = AW'({1'b0, {(PW-1){1'b1}}});
    localparam logic signed [AW-1:0] PLO = -(AW'(1) <<< (PW-1));
    localparam logic signed [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             st_reg, st_next;
    logic [2:0]             op_reg, op_next;   // six angle evaluations
    logic signed [PW-1:0]   xp_reg, xp_next, yp_reg, yp_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic signed [AW-1:0]   acc_reg [3];
    logic signed [AW-1:0]   ang_reg;
    logic [1:0]             sc_reg;
    logic signed [PW-1:0]   sat [3];
    logic                   last_reg;

    logic [COEF_W-1:0]      mc;
    logic signed [PW-1:0]   mp;
    logic signed [PW+COEF_W-1:0] prod;
    logic signed [AW-1:0]   c_sin, c_cos;
    logic                   c_done;
    logic signed [AW+COEF_W-1:0] mprod;
    logic [COEF_W-1:0]      mult_coef;
    logic [1:0]             term_sel;
    logic signed [PW+8:0]   scl;
    logic signed [PW+8:0]   scl_sh;
    logic [CW-1:0]          cnt_inc;

    // op: 0 a*y,1 a*x (x'), 2 b*x,3 b*y (y'), 4 d*y,5 c*x (z)
    always_comb
    begin
        case (op_reg)
            3'd0: begin mc = coef_a; mp = yp_reg; mult_coef = coef_c; end
            3'd1: begin mc = coef_a; mp = xp_reg; mult_coef = coef_c; end
            3'd2: begin mc = coef_b; mp = xp_reg; mult_coef = coef_d; end
            3'd3: begin mc = coef_b; mp = yp_reg; mult_coef = coef_d; end
            3'd4: begin mc = coef_d; mp = yp_reg; mult_coef = coef_a; end
            default: begin mc = coef_c; mp = xp_reg; mult_coef = coef_a; end
        endcase
    end
    assign term_sel = op_reg[2:1];
    assign prod  = $signed(mc) * mp;
    assign mprod = $signed(mult_coef) * c_cos;

    cap_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (st_reg == ST_MUL),
        .angle   (ang_reg),
        .done    (c_done),
        .sin_out (c_sin),
        .cos_out (c_cos)
    );

    generate
        for (genvar k = 0; k < 3; k++)
        begin : g_sat
            assign sat[k] = (acc_reg[k] > PHI) ? PW'(PHI) :
                            (acc_reg[k] < PLO) ? PW'(PLO) : PW'(acc_reg[k]);
        end
    endgenerate

    assign scl    = $signed(sat[sc_reg]) * $signed(10'sd120)
                    + (($signed((PW+9)'(1))) <<< (FRAC_BITS - 5));
    assign scl_sh = scl >>> (FRAC_BITS - 4);
    assign cnt_inc = CW'(cnt_reg) + CW'(1);
    assign q_pop  = (st_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        st_next  = st_reg;
        op_next  = op_reg;
        xp_next  = xp_reg;
        yp_next  = yp_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.restart)
                    begin
                        xp_next  = ONE;
                        yp_next  = ONE;
                        cnt_next = '0;
                    end
                    op_next = 3'd0;
                    st_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                st_next = ST_MUL;   // ang_reg loaded here
            end
            ST_MUL:
            begin
                st_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (c_done)
                begin
                    if (op_reg == 3'd5)
                    begin
                        st_next = ST_SCL;
                    end
                    else
                    begin
                        op_next = op_reg + 3'd1;
                        st_next = ST_WAIT;
                    end
                end
            end
            ST_SCL:
            begin
                if (sc_reg == 2'd2)
                begin
                    st_next = ST_OUT;
                    if (last_reg)
                    begin
                        xp_next  = ONE;
                        yp_next  = ONE;
                        cnt_next = '0;
                    end
                    else
                    begin
                        xp_next  = sat[0];
                        yp_next  = sat[1];
                        cnt_next = cnt_inc[COUNT_WIDTH-1:0];
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            op_reg  <= 3'd0;
            xp_reg  <= ONE;
            yp_reg  <= ONE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            op_reg  <= op_next;
            xp_reg  <= xp_next;
            yp_reg  <= yp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_WAIT)
        begin
            ang_reg <= AW'(prod >>> 12);
        end
        if (st_reg == ST_IDLE)
        begin
            sc_reg   <= 2'd0;
            // counter after a possible restart of this request
            last_reg <= (CW'(cnt_next) + CW'(1) >= CW'(point_count));
            point_index <= 20'(cnt_next);
        end
        if (st_reg == ST_ACC && c_done)
        begin
            if (!op_reg[0])
            begin
                acc_reg[term_sel] <= c_sin;
            end
            else
            begin
                acc_reg[term_sel] <= acc_reg[term_sel] + AW'(mprod >>> 12);
            end
        end
        if (st_reg == ST_SCL)
        begin
            sc_reg <= sc_reg + 2'd1;
            case (sc_reg)
                2'd0: point_x <= (scl_sh > 8191) ? OUT_HI :
                                 (scl_sh < -8192) ? OUT_LO : OUT_W'(scl_sh);
                2'd1: point_y <= (scl_sh > 8191) ? OUT_HI :
                                 (scl_sh < -8192) ? OUT_LO : OUT_W'(scl_sh);
                default: point_z <= (scl_sh > 8191) ? OUT_HI :
                                 (scl_sh < -8192) ? OUT_LO : OUT_W'(scl_sh);
            endcase
        end
    end

    assign out_valid = (st_reg == ST_OUT);
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == ST_IDLE) else $error("pop while busy");
    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg <= 3'd5) else $error("op out of range");
`endif
endmodule

// ===== design/clifford_attractor_point_gen.sv =====
// Top level of the Clifford attractor point generator.
// Usage:
//   in  : valid/ready request channel, payload restart (1 starts a new run).
//   out : valid/ready result channel with point_x/y/z (Q9.4, scaled by 120),
//         point_index and last.
//   cfg : APB port, registers coef_a..coef_d (Q2.12) and point_count at
//         byte addresses 0,4,8,12,16; write only while idle.
// Each request yields exactly one result. A two-entry queue decouples the
// request side from the compute engine, so requests are taken while a
// result waits. One point takes six sine/cosine evaluations through one
// shared CORDIC unit; each evaluation removes multiples of 2*pi in range
// reduction, folds the angle into +-pi/2 and runs CORDIC_STEPS iterations.
// Reset restores the registers, the position (1,1) and counter zero.
// When the receiver stalls the result is held and the engine waits;
// the queue keeps accepting until full.
module clifford_attractor_point_gen
    import cap_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_WIDTH  = 20,
    parameter int CORDIC_STEPS = 18
)
(
    input  logic        clk,
    input  logic        rst_n,
    cap_in_if.sink      req,
    cap_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [19:0]       count_reg;
    logic              q_valid, q_pop, wr;
    cap_req_t          q_data;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= 15'd4096;
            coef_b_reg <= 15'd4096;
            coef_c_reg <= 15'd4096;
            coef_d_reg <= 15'd4096;
            count_reg  <= 20'd100000;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_COEF_A: coef_a_reg <= pwdata[14:0];
                REG_COEF_B: coef_b_reg <= pwdata[14:0];
                REG_COEF_C: coef_c_reg <= pwdata[14:0];
                REG_COEF_D: coef_d_reg <= pwdata[14:0];
                REG_COUNT:  count_reg  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_COEF_A: prdata = {17'd0, coef_a_reg};
            REG_COEF_B: prdata = {17'd0, coef_b_reg};
            REG_COEF_C: prdata = {17'd0, coef_c_reg};
            REG_COEF_D: prdata = {17'd0, coef_d_reg};
            REG_COUNT:  prdata = {12'd0, count_reg};
            default:    prdata = 32'd0;
        endcase
    end

    cap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_restart (req.restart),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data)
    );

    cap_back #(
        .FRAC_BITS    (FRAC_BITS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .coef_a      (coef_a_reg),
        .coef_b      (coef_b_reg),
        .coef_c      (coef_c_reg),
        .coef_d      (coef_d_reg),
        .point_count (count_reg),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .point_x     (rsp.point_x),
        .point_y     (rsp.point_y),
        .point_z     (rsp.point_z),
        .point_index (rsp.point_index),
        .last        (rsp.last)
    );

`ifndef NO_ASSERTIONS
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");
    a_one_per_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready |=> !rsp.valid) else $error("result repeated");
    a_count_nz_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && count_reg <= 20'd1 |-> rsp.last) else $error("last missing");
`endif
endmodule

// ===== tb/sv/clifford_attractor_point_gen_tb.sv =====
// Self-checking testbench for the Clifford attractor point generator.
module clifford_attractor_point_gen_tb
    import cap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 16;
    localparam int  STEPS     = 18;
    localparam int  LATENCY   = 6 * (STEPS + 6) + 5;
    localparam int  MAX_CYCLES = 2000000;
    localparam int  NUM_RANDOM = 1400;

    typedef struct {
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic signed [13:0] pz;
        logic [19:0]        index;
        logic               last;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cap_in_if  req_ch ();
    cap_out_if rsp_ch ();

    clifford_attractor_point_gen dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and register mirror
    logic signed [14:0] coef_a_m, coef_b_m, coef_c_m, coef_d_m;
    logic [19:0]        count_m;
    longint             pos_x, pos_y;
    logic [19:0]        run_idx;

    point_t expected_points[$];
    int     errors;
    int     cycle_count;
    int     recv_hold;
    bit     no_gaps;

    longint atan_tbl[28] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128,
        64, 32, 16, 8
    };

    function automatic longint round_q30(longint c);
        return (c + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
        longint pi_v, two_pi, half_pi, r, cx, cy, cz, dx, dy;
        bit     flip;
        pi_v    = round_q30(64'd3373259426);
        two_pi  = 2 * pi_v;
        half_pi = round_q30(64'd3373259426 / 2);
        flip    = 0;
        r = (ang + pi_v) % two_pi;
        if (r < 0)
            r += two_pi;
        cz = r - pi_v;
        if (cz > half_pi)
        begin
            cz = pi_v - cz;
            flip = 1;
        end
        else if (cz < -half_pi)
        begin
            cz = -pi_v - cz;
            flip = 1;
        end
        cx = round_q30(64'd652032874);
        cy = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= round_q30(atan_tbl[i]);
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += round_q30(atan_tbl[i]);
            end
        end
        s = cy;
        c = flip ? -cx : cx;
    endtask

    // sin(sc*sp) + m*cos(cc*cp)
    task automatic map_term(input logic signed [14:0] sc, input longint sp,
                            input logic signed [14:0] m, input logic signed [14:0] cc,
                            input longint cp, output longint v);
        longint s1, c1, s2, c2;
        cordic_sin_cos((longint'(sc) * sp) >>> 12, s1, c1);
        cordic_sin_cos((longint'(cc) * cp) >>> 12, s2, c2);
        v = s1 + ((longint'(m) * c2) >>> 12);
    endtask

    function automatic longint clamp_pos(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (FRAC + 4)) - 1;
        lo = -(longint'(1) <<< (FRAC + 4));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic logic signed [13:0] to_screen(longint v);
        longint s;
        s = (v * 120 + (longint'(1) <<< (FRAC - 5))) >>> (FRAC - 4);
        if (s > 8191)
            s = 8191;
        if (s < -8192)
            s = -8192;
        return s[13:0];
    endfunction

    task automatic predict_point(input logic restart);
        longint nx, ny, nz;
        point_t p;
        logic   end_run;
        if (restart)
        begin
            pos_x   = longint'(1) <<< FRAC;
            pos_y   = longint'(1) <<< FRAC;
            run_idx = '0;
        end
        map_term(coef_a_m, pos_y, coef_c_m, coef_a_m, pos_x, nx);
        map_term(coef_b_m, pos_x, coef_d_m, coef_b_m, pos_y, ny);
        map_term(coef_d_m, pos_y, coef_a_m, coef_c_m, pos_x, nz);
        nx = clamp_pos(nx);
        ny = clamp_pos(ny);
        nz = clamp_pos(nz);
        // a zero count behaves as one
        end_run = (longint'(run_idx) + 1 >= longint'(count_m));
        p.px    = to_screen(nx);
        p.py    = to_screen(ny);
        p.pz    = to_screen(nz);
        p.index = run_idx;
        p.last  = end_run;
        expected_points.push_back(p);
        if (end_run)
        begin
            pos_x   = longint'(1) <<< FRAC;
            pos_y   = longint'(1) <<< FRAC;
            run_idx = '0;
        end
        else
        begin
            pos_x   = nx;
            pos_y   = ny;
            run_idx = run_idx + 1'b1;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= MAX_CYCLES)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (recv_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (recv_hold) @(posedge clk);
                recv_hold = 0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 5);
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d z=%0d idx=%0d last=%0b", $time,
                         rsp_ch.point_x, rsp_ch.point_y, rsp_ch.point_z,
                         rsp_ch.point_index, rsp_ch.last);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (rsp_ch.point_x !== e.px)
                begin
                    $display("%0t: point_x expected %0d actual %0d", $time, e.px, rsp_ch.point_x);
                    errors++;
                end
                if (rsp_ch.point_y !== e.py)
                begin
                    $display("%0t: point_y expected %0d actual %0d", $time, e.py, rsp_ch.point_y);
                    errors++;
                end
                if (rsp_ch.point_z !== e.pz)
                begin
                    $display("%0t: point_z expected %0d actual %0d", $time, e.pz, rsp_ch.point_z);
                    errors++;
                end
                if (rsp_ch.point_index !== e.index)
                begin
                    $display("%0t: point_index expected %0d actual %0d", $time, e.index,
                             rsp_ch.point_index);
                    errors++;
                end
                if (rsp_ch.last !== e.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, e.last, rsp_ch.last);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(input logic restart);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.restart <= restart;
        req_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_point(restart);
    endtask

    // request side goes quiet and every point comes back
    task automatic drain_points();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY / 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_COEF_A: coef_a_m = value[14:0];
            REG_COEF_B: coef_b_m = value[14:0];
            REG_COEF_C: coef_c_m = value[14:0];
            REG_COEF_D: coef_d_m = value[14:0];
            REG_COUNT:  count_m  = value[19:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int a, input int b, input int c, input int d,
                              input int cnt);
        drain_points();
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
        write_reg(REG_COUNT, cnt);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_defaults();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_coef_extremes();
        set_config(12288, 12288, 12288, 12288, 100000);
        send_request(1'b1);
        send_request(1'b0);
        set_config(-12288, -12288, -12288, -12288, 100000);
        send_request(1'b1);
        send_request(1'b0);
        set_config(12288, -12288, -12288, 12288, 100000);
        send_request(1'b1);
        send_request(1'b0);
        // beyond +-3: the scaled output saturates
        set_config(16383, -16384, 16383, -16384, 100000);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_run_length();
        // zero count: every point ends its run
        set_config(4096, 4096, 4096, 4096, 0);
        send_request(1'b0);
        send_request(1'b0);
        set_config(4096, 4096, 4096, 4096, 1);
        send_request(1'b0);
        send_request(1'b0);
        set_config(-5000, 7000, 3000, -9000, 3);
        for (int i = 0; i < 5; i++)
            send_request(1'b0);
        // count lowered mid-run: counter already past it
        set_config(-5000, 7000, 3000, -9000, 50);
        for (int i = 0; i < 4; i++)
            send_request(1'b0);
        set_config(-5000, 7000, 3000, -9000, 2);
        send_request(1'b0);
        set_config(-5000, 7000, 3000, -9000, 1048575);
        send_request(1'b0);
        send_request(1'b1);
        // write to an unused register slot is ignored
        drain_points();
        write_reg(3'd5, 32'hFFFF_FFFF);
        psel    <= 1'b0;
        penable <= 1'b0;
        send_request(1'b0);
    endtask

    task automatic test_backpressure();
        set_config(6000, -7000, 8000, -4000, 7);
        recv_hold = 600;
        for (int i = 0; i < 12; i++)
            send_request(1'b0);
        drain_points();
    endtask

    task automatic test_random();
        int a, b, c, d, cnt, done, phase_len;
        done = 0;
        while (done < NUM_RANDOM)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                a = $urandom_range(0, 32767) - 16384;
                b = $urandom_range(0, 32767) - 16384;
                c = $urandom_range(0, 32767) - 16384;
                d = $urandom_range(0, 32767) - 16384;
            end
            else
            begin
                a = $urandom_range(0, 24576) - 12288;
                b = $urandom_range(0, 24576) - 12288;
                c = $urandom_range(0, 24576) - 12288;
                d = $urandom_range(0, 24576) - 12288;
            end
            case ($urandom_range(0, 5))
                0: cnt = $urandom_range(0, 1048575);
                1: cnt = $urandom_range(0, 3);
                default: cnt = $urandom_range(4, 60);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            set_config(a, b, c, d, cnt);
            phase_len = $urandom_range(60, 140);
            for (int i = 0; i < phase_len; i++)
                send_request($urandom_range(0, 19) == 0);
            done += phase_len;
            no_gaps = 0;
        end
    endtask

    initial
    begin
        errors    = 0;
        recv_hold = 0;
        no_gaps   = 0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        coef_a_m = 15'sd4096;
        coef_b_m = 15'sd4096;
        coef_c_m = 15'sd4096;
        coef_d_m = 15'sd4096;
        count_m  = 20'd100000;
        pos_x    = longint'(1) <<< FRAC;
        pos_y    = longint'(1) <<< FRAC;
        run_idx  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_coef_extremes();
        test_run_length();
        test_backpressure();
        test_random();
        test_backpressure();

        drain_points();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cap_pkg.sv
design/cap_if.sv
design/cap_front.sv
design/cap_cordic.sv
design/cap_back.sv
design/clifford_attractor_point_gen.sv
tb/sv/clifford_attractor_point_gen_tb.sv
